### sv/fpq_pkg.sv
// Package for the frame presentation queue.
// Holds beat types, action and fault codes, and the controller/datapath interface structs.
// No dependencies.
package fpq_pkg;

    localparam int ACTION_W = 3;
    localparam int HANDLE_W = 4;
    localparam int TIME_W   = 40;
    localparam int STIME_W  = 48;
    localparam int DROP_W   = 32;
    localparam int FAULT_W  = 2;

    localparam logic [ACTION_W-1:0] ACT_INIT   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_TAKE   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_QUEUE  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_START  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_PULL   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_RETURN = 3'd5;

    localparam logic [FAULT_W-1:0] FAULT_NONE       = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_FULL_OVF   = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_FREE_OVF   = 2'd2;
    localparam logic [FAULT_W-1:0] FAULT_START_EMPTY = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [HANDLE_W-1:0] frame_handle;
        logic [TIME_W-1:0]   time_value;
    } in_beat_t;

    typedef struct packed {
        logic [HANDLE_W-1:0]       handle_out;
        logic                      handle_valid;
        logic signed [STIME_W-1:0] handle_time;
        logic [DROP_W-1:0]         drop_count;
        logic                      is_started;
        logic [FAULT_W-1:0]        fault_code;
    } out_beat_t;

    typedef struct packed {
        logic load;
        logic fill_wr;
        logic init_done;
        logic take_use;
        logic queue_op;
        logic start_fault;
        logic offs_cap;
        logic rd_walk_next;
        logic walk_wr;
        logic start_done;
        logic pull_pop;
        logic ret_push;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                free_empty;
        logic                full_empty;
        logic                full_full;
        logic                started;
        logic                walk_last;
        logic                due;
        logic                fill_last;
        logic                out_busy;
    } status_t;

endpackage

### sv/fpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/fpq_ctrl.sv
// Controller state machine of the frame presentation queue.
// Sequences each action over the datapath; depends on fpq_pkg.
module fpq_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  fpq_pkg::status_t status,
    output fpq_pkg::cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_DISPATCH  = 7'b0000010,
        ST_FILL      = 7'b0000100,
        ST_WALK      = 7'b0001000,
        ST_PULL_CHK  = 7'b0010000,
        ST_PULL_WAIT = 7'b0100000,
        ST_FINISH    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                state_next = ST_FINISH;
                case (status.action)
                    fpq_pkg::ACT_INIT: begin
                        state_next = ST_FILL;
                    end
                    fpq_pkg::ACT_TAKE: begin
                        cmd.take_use = !status.free_empty;
                    end
                    fpq_pkg::ACT_QUEUE: begin
                        cmd.queue_op = 1'b1;
                    end
                    fpq_pkg::ACT_START: begin
                        if (status.full_empty) begin
                            cmd.start_fault = 1'b1;
                        end else begin
                            cmd.offs_cap = 1'b1;
                            state_next = ST_WALK;
                        end
                    end
                    fpq_pkg::ACT_PULL: begin
                        if (status.started) begin
                            state_next = ST_PULL_CHK;
                        end
                    end
                    fpq_pkg::ACT_RETURN: begin
                        cmd.ret_push = 1'b1;
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_FILL: begin
                cmd.fill_wr = 1'b1;
                if (status.fill_last) begin
                    cmd.init_done = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_WALK: begin
                cmd.walk_wr = 1'b1;
                cmd.rd_walk_next = 1'b1;
                if (status.walk_last) begin
                    cmd.start_done = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_PULL_CHK: begin
                if (!status.full_empty && status.due) begin
                    cmd.pull_pop = 1'b1;
                    state_next = ST_PULL_WAIT;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_PULL_WAIT: begin
                state_next = ST_PULL_CHK;
            end
            ST_FINISH: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/fpq_datapath.sv
// Datapath of the frame presentation queue: ring pointers, ring memories,
// time arithmetic and the output register. Depends on fpq_pkg and fpq_ram.
module fpq_datapath #(
    parameter int RING_SLOTS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fpq_pkg::in_beat_t   s_data,
    input  fpq_pkg::cmd_t       cmd,
    output fpq_pkg::status_t    status,
    output logic                m_valid,
    input  logic                m_ready,
    output fpq_pkg::out_beat_t  m_data
);

    localparam int PTR_W = $clog2(RING_SLOTS);
    localparam int HW    = fpq_pkg::HANDLE_W;
    localparam int SW    = fpq_pkg::STIME_W;
    localparam int TW    = fpq_pkg::TIME_W;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    fpq_pkg::in_beat_t  in_reg;
    fpq_pkg::out_beat_t m_data_reg;
    logic               m_valid_reg;

    logic [PTR_W-1:0] free_head_reg, free_tail_reg, full_head_reg, full_tail_reg;
    logic [PTR_W-1:0] fill_cnt_reg, walk_reg;
    logic [SW-1:0]    start_offset_reg, offs_reg, h_time_reg;
    logic             started_reg, h_valid_reg;
    logic [HW-1:0]    h_out_reg;
    logic [fpq_pkg::DROP_W-1:0]  dropped_reg;
    logic [fpq_pkg::FAULT_W-1:0] fault_reg;

    logic [HW-1:0]    free_rdata, hdl_rdata;
    logic [SW-1:0]    time_rdata;
    logic             free_we, time_we, queue_go;
    logic [PTR_W-1:0] free_waddr, time_waddr, time_raddr;
    logic [HW-1:0]    free_wdata;
    logic [SW-1:0]    time_wdata, tval_ext;
    logic             push_req, push_go, free_full, full_full;
    logic [HW-1:0]    push_handle;
    logic [fpq_pkg::FAULT_W-1:0] fault_next;

    assign tval_ext    = {{(SW - TW){1'b0}}, in_reg.time_value};
    assign free_full   = (ring_next(free_tail_reg) == free_head_reg);
    assign full_full   = (ring_next(full_tail_reg) == full_head_reg);
    assign push_req    = cmd.ret_push || (cmd.pull_pop && h_valid_reg);
    assign push_go     = push_req && !free_full;
    assign push_handle = cmd.ret_push ? in_reg.frame_handle : h_out_reg;
    assign queue_go    = cmd.queue_op && !full_full;

    assign free_we    = cmd.fill_wr || push_go;
    assign free_waddr = cmd.fill_wr ? fill_cnt_reg : free_tail_reg;
    assign free_wdata = cmd.fill_wr ? HW'(fill_cnt_reg) : push_handle;

    assign time_we    = queue_go || cmd.walk_wr;
    assign time_waddr = cmd.walk_wr ? walk_reg : full_tail_reg;
    assign time_wdata = cmd.walk_wr ? (time_rdata + offs_reg) : (tval_ext + start_offset_reg);
    assign time_raddr = cmd.rd_walk_next ? ring_next(walk_reg) : full_head_reg;

    fpq_ram #(.WIDTH(HW), .DEPTH(RING_SLOTS)) u_free_ram (
        .aclk  (aclk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (free_head_reg),
        .rdata (free_rdata)
    );

    fpq_ram #(.WIDTH(HW), .DEPTH(RING_SLOTS)) u_hdl_ram (
        .aclk  (aclk),
        .we    (queue_go),
        .waddr (full_tail_reg),
        .wdata (in_reg.frame_handle),
        .raddr (full_head_reg),
        .rdata (hdl_rdata)
    );

    fpq_ram #(.WIDTH(SW), .DEPTH(RING_SLOTS)) u_time_ram (
        .aclk  (aclk),
        .we    (time_we),
        .waddr (time_waddr),
        .wdata (time_wdata),
        .raddr (time_raddr),
        .rdata (time_rdata)
    );

    always_comb begin
        fault_next = fault_reg;
        if (fault_reg == fpq_pkg::FAULT_NONE) begin
            if (cmd.queue_op && full_full) begin
                fault_next = fpq_pkg::FAULT_FULL_OVF;
            end else if (push_req && free_full) begin
                fault_next = fpq_pkg::FAULT_FREE_OVF;
            end else if (cmd.start_fault) begin
                fault_next = fpq_pkg::FAULT_START_EMPTY;
            end
        end
    end

    always_comb begin
        status.action     = in_reg.action;
        status.free_empty = (free_head_reg == free_tail_reg);
        status.full_empty = (full_head_reg == full_tail_reg);
        status.full_full  = full_full;
        status.started    = started_reg;
        status.walk_last  = (ring_next(walk_reg) == full_tail_reg);
        status.due        = ($signed({time_rdata[SW-1], time_rdata}) <=
                             $signed({1'b0, tval_ext}));
        status.fill_last  = (fill_cnt_reg == PTR_W'(RING_SLOTS - 2));
        status.out_busy   = m_valid_reg && !m_ready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= s_data;
        end
        if (cmd.offs_cap) begin
            offs_reg <= tval_ext - time_rdata;
        end
        if (cmd.out_load) begin
            m_data_reg.handle_out   <= h_out_reg;
            m_data_reg.handle_valid <= h_valid_reg;
            m_data_reg.handle_time  <= $signed(h_time_reg);
            m_data_reg.drop_count   <= dropped_reg;
            m_data_reg.is_started   <= started_reg;
            m_data_reg.fault_code   <= fault_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg    <= '0;
            free_tail_reg    <= '0;
            full_head_reg    <= '0;
            full_tail_reg    <= '0;
            fill_cnt_reg     <= '0;
            walk_reg         <= '0;
            start_offset_reg <= '0;
            started_reg      <= 1'b0;
            dropped_reg      <= '0;
            fault_reg        <= fpq_pkg::FAULT_NONE;
            h_out_reg        <= '0;
            h_valid_reg      <= 1'b0;
            h_time_reg       <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            fault_reg <= fault_next;
            if (cmd.load) begin
                h_out_reg    <= '0;
                h_valid_reg  <= 1'b0;
                h_time_reg   <= '0;
                fill_cnt_reg <= '0;
            end
            if (cmd.fill_wr) begin
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
            end
            if (cmd.init_done) begin
                free_head_reg    <= '0;
                free_tail_reg    <= PTR_W'(RING_SLOTS - 1);
                full_head_reg    <= '0;
                full_tail_reg    <= '0;
                start_offset_reg <= '0;
                started_reg      <= 1'b0;
            end
            if (cmd.take_use) begin
                h_out_reg     <= free_rdata;
                h_valid_reg   <= 1'b1;
                free_head_reg <= ring_next(free_head_reg);
            end
            if (queue_go) begin
                full_tail_reg <= ring_next(full_tail_reg);
            end
            if (push_go) begin
                free_tail_reg <= ring_next(free_tail_reg);
            end
            if (cmd.offs_cap) begin
                walk_reg <= full_head_reg;
            end
            if (cmd.walk_wr) begin
                walk_reg <= ring_next(walk_reg);
            end
            if (cmd.start_done) begin
                start_offset_reg <= offs_reg;
                started_reg      <= 1'b1;
            end
            if (cmd.pull_pop) begin
                if (h_valid_reg) begin
                    dropped_reg <= dropped_reg + 1'b1;
                end
                h_out_reg     <= hdl_rdata;
                h_time_reg    <= time_rdata;
                h_valid_reg   <= 1'b1;
                full_head_reg <= ring_next(full_head_reg);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### sv/frame_presentation_queue_core.sv
// Top level of the frame presentation queue: controller plus datapath.
// Depends on fpq_pkg, fpq_ctrl, fpq_datapath and fpq_ram.
//
//   Channel   Direction  Handshake          Beat type
//   s_        in         s_valid / s_ready  fpq_pkg::in_beat_t
//   m_        out        m_valid / m_ready  fpq_pkg::out_beat_t
//
// One beat is taken at a time. Take free, queue full, return free and unused actions
// pass through dispatch and finish; init adds the free ring fill sweep before finish.
// Start walks the N queued entries, one time memory update per cycle.
// Pull, once started, pops K entries through a check and a wait state per memory read;
// a pull before start goes from dispatch straight to finish.
// Reset clears pointers, flags, counters and the fault code; ring memories are not cleared.
// A stalled result waits in the output register; the next beat is still accepted.
module frame_presentation_queue_core #(
    parameter int RING_SLOTS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fpq_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output fpq_pkg::out_beat_t m_data
);

    fpq_pkg::cmd_t    cmd;
    fpq_pkg::status_t status;

    fpq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fpq_datapath #(.RING_SLOTS(RING_SLOTS)) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### sv/fpq_checker.sv
// Port-level checker for the frame presentation queue, bound to the top level.
// Depends on fpq_pkg and frame_presentation_queue_core.
module fpq_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input fpq_pkg::in_beat_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input fpq_pkg::out_beat_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result beat changed while stalled.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Input ready the cycle after a beat was taken.");

    a_fault_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.fault_code != fpq_pkg::FAULT_NONE)
        |=> m_data.fault_code == $past(m_data.fault_code))
        else $error("Fault code changed after being set.");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("Block not idle after reset.");

endmodule

bind frame_presentation_queue_core fpq_checker u_fpq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### bench/tb.sv
// Self-checking bench for frame_presentation_queue_core: directed beats, then random sessions.
// Predicts every result from its own model of the two handle rings and checks each field.
// Depends on fpq_pkg and frame_presentation_queue_core.
module tb;

    localparam int SLOTS = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ACTIONS = 2000;
    localparam logic [fpq_pkg::ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [fpq_pkg::ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
    localparam logic [fpq_pkg::TIME_W-1:0] TIME_MAX = '1;

    typedef struct {
        fpq_pkg::in_beat_t beat;
        bit                drain;
    } send_item_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    fpq_pkg::in_beat_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    fpq_pkg::out_beat_t m_data;

    send_item_t         beats_to_send[$];
    fpq_pkg::out_beat_t outcomes[$];
    fpq_pkg::out_beat_t want_beat;

    logic [fpq_pkg::HANDLE_W-1:0] free_buf[SLOTS];
    logic [fpq_pkg::HANDLE_W-1:0] disp_buf[SLOTS];
    logic [fpq_pkg::STIME_W-1:0]  disp_time[SLOTS];
    logic [3:0]                   free_rd = '0;
    logic [3:0]                   free_wr = '0;
    logic [3:0]                   disp_rd = '0;
    logic [3:0]                   disp_wr = '0;
    logic [fpq_pkg::STIME_W-1:0]  align_offset = '0;
    logic                         running = 1'b0;
    logic [fpq_pkg::DROP_W-1:0]   late_total = '0;
    logic [fpq_pkg::FAULT_W-1:0]  fault_now = fpq_pkg::FAULT_NONE;

    bit calm = 1'b0;
    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    bit send_next;
    int send_wait = 0;
    int recv_wait = 0;
    int idle_cycles = 0;
    int errors = 0;
    int actions_done = 0;
    int frames_shown = 0;
    int planned = 0;

    frame_presentation_queue_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    function automatic void record_fault(logic [fpq_pkg::FAULT_W-1:0] code);
        if (fault_now == fpq_pkg::FAULT_NONE) begin
            fault_now = code;
        end
    endfunction

    function automatic void give_back(logic [fpq_pkg::HANDLE_W-1:0] hnd);
        logic [3:0] nxt;
        nxt = free_wr + 4'd1;
        if (nxt == free_rd) begin
            record_fault(fpq_pkg::FAULT_FREE_OVF);
        end else begin
            free_buf[free_wr] = hnd;
            free_wr = nxt;
        end
    endfunction

    function automatic fpq_pkg::out_beat_t apply_action(fpq_pkg::in_beat_t b);
        fpq_pkg::out_beat_t                 r;
        logic [3:0]                         nxt;
        logic [3:0]                         idx;
        logic [fpq_pkg::STIME_W-1:0]        offs;
        logic signed [fpq_pkg::STIME_W-1:0] due_at;
        int                                 k;
        r = '0;
        case (b.action)
            fpq_pkg::ACT_INIT: begin
                for (k = 0; k < SLOTS - 1; k++) begin
                    free_buf[k] = k[3:0];
                end
                free_rd = '0;
                free_wr = 4'(SLOTS - 1);
                disp_rd = '0;
                disp_wr = '0;
                align_offset = '0;
                running = 1'b0;
            end
            fpq_pkg::ACT_TAKE: begin
                if (free_rd != free_wr) begin
                    r.handle_out = free_buf[free_rd];
                    r.handle_valid = 1'b1;
                    free_rd = free_rd + 4'd1;
                end
            end
            fpq_pkg::ACT_QUEUE: begin
                nxt = disp_wr + 4'd1;
                if (nxt == disp_rd) begin
                    record_fault(fpq_pkg::FAULT_FULL_OVF);
                end else begin
                    disp_buf[disp_wr] = b.frame_handle;
                    disp_time[disp_wr] = {8'd0, b.time_value} + align_offset;
                    disp_wr = nxt;
                end
            end
            fpq_pkg::ACT_START: begin
                if (disp_rd == disp_wr) begin
                    record_fault(fpq_pkg::FAULT_START_EMPTY);
                end else begin
                    offs = {8'd0, b.time_value} - disp_time[disp_rd];
                    for (idx = disp_rd; idx != disp_wr; idx = idx + 4'd1) begin
                        disp_time[idx] = disp_time[idx] + offs;
                    end
                    align_offset = offs;
                    running = 1'b1;
                end
            end
            fpq_pkg::ACT_PULL: begin
                if (running) begin
                    while (disp_rd != disp_wr) begin
                        due_at = disp_time[disp_rd];
                        if (longint'(due_at) > longint'(b.time_value)) begin
                            break;
                        end
                        if (r.handle_valid) begin
                            late_total = late_total + 1;
                            give_back(r.handle_out);
                        end
                        r.handle_out = disp_buf[disp_rd];
                        r.handle_time = disp_time[disp_rd];
                        r.handle_valid = 1'b1;
                        disp_rd = disp_rd + 4'd1;
                    end
                    if (r.handle_valid) begin
                        frames_shown++;
                    end
                end
            end
            fpq_pkg::ACT_RETURN: begin
                give_back(b.frame_handle);
            end
            default: begin
            end
        endcase
        r.drop_count = late_total;
        r.is_started = running;
        r.fault_code = fault_now;
        return r;
    endfunction

    function automatic int draw_wait();
        if (calm) begin
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [fpq_pkg::TIME_W-1:0] rand_time();
        case ($urandom_range(0, 3))
            0: return fpq_pkg::TIME_W'($urandom_range(0, 1000));
            1: return TIME_MAX - fpq_pkg::TIME_W'($urandom_range(0, 1000));
            default: return fpq_pkg::TIME_W'({$urandom, $urandom});
        endcase
    endfunction

    task automatic add_beat(logic [fpq_pkg::ACTION_W-1:0] act,
                            logic [fpq_pkg::HANDLE_W-1:0] hnd,
                            logic [fpq_pkg::TIME_W-1:0] tv, bit drain = 1'b0);
        send_item_t item;
        item.beat.action = act;
        item.beat.frame_handle = hnd;
        item.beat.time_value = tv;
        item.drain = drain;
        beats_to_send.push_back(item);
        planned++;
    endtask

    task automatic add_session();
        int takes;
        int fills;
        int pulls;
        int period;
        int j;
        logic [fpq_pkg::TIME_W-1:0] base;
        logic [fpq_pkg::TIME_W-1:0] now;
        if ($urandom_range(0, 3) == 0) begin
            add_beat(fpq_pkg::ACT_INIT, 4'($urandom), rand_time());
        end
        takes = $urandom_range(0, 5);
        repeat (takes) add_beat(fpq_pkg::ACT_TAKE, 4'($urandom), rand_time());
        fills = $urandom_range(0, 16);
        period = $urandom_range(1, 40);
        base = rand_time();
        for (j = 0; j < fills; j++) begin
            add_beat(fpq_pkg::ACT_QUEUE, 4'($urandom), base + fpq_pkg::TIME_W'(j * period));
        end
        now = base + fpq_pkg::TIME_W'($urandom_range(0, 2 * period));
        add_beat(fpq_pkg::ACT_START, 4'($urandom), now);
        pulls = $urandom_range(1, 8);
        repeat (pulls) begin
            now = now + fpq_pkg::TIME_W'($urandom_range(0, 3 * period));
            add_beat(fpq_pkg::ACT_PULL, 4'($urandom), now);
            if ($urandom_range(0, 1) == 0) begin
                add_beat(fpq_pkg::ACT_RETURN, 4'($urandom), rand_time());
            end
        end
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] seen);
        if (seen !== want) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, seen);
            errors++;
        end
    endtask

    // Input driver: a new beat is presented only after its wait has run out.
    always @(negedge aclk) begin
        send_next = s_valid;
        if (in_taken) begin
            send_next = 1'b0;
            in_taken = 1'b0;
        end
        if (aresetn && !send_next) begin
            if (send_wait > 0) begin
                send_wait--;
            end else if (beats_to_send.size() > 0 &&
                         !(beats_to_send[0].drain && outcomes.size() > 0)) begin
                s_data <= beats_to_send[0].beat;
                beats_to_send.pop_front();
                send_next = 1'b1;
                send_wait = draw_wait();
            end
        end
        s_valid <= send_next;
    end

    always @(negedge aclk) begin
        if (out_taken) begin
            out_taken = 1'b0;
            recv_wait = draw_wait();
        end
        m_ready <= (recv_wait == 0);
        if (recv_wait > 0 && m_valid) begin
            recv_wait--;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                out_taken = 1'b1;
                if (outcomes.size() == 0) begin
                    $display("%0t: result beat with nothing expected: %h", $time, m_data);
                    errors++;
                end else begin
                    want_beat = outcomes.pop_front();
                    check_field("handle_out", want_beat.handle_out, m_data.handle_out);
                    check_field("handle_valid", want_beat.handle_valid, m_data.handle_valid);
                    check_field("handle_time", want_beat.handle_time, m_data.handle_time);
                    check_field("drop_count", want_beat.drop_count, m_data.drop_count);
                    check_field("is_started", want_beat.is_started, m_data.is_started);
                    check_field("fault_code", want_beat.fault_code, m_data.fault_code);
                end
            end
            if (s_valid && s_ready) begin
                outcomes.push_back(apply_action(s_data));
                in_taken = 1'b1;
                actions_done++;
                if ($urandom_range(0, 149) == 0) begin
                    calm = !calm;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && !(s_valid && s_ready) && !(m_valid && m_ready)) begin
            idle_cycles++;
        end else begin
            idle_cycles = 0;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("frame_presentation_queue_core: mismatch");
            $finish;
        end
    end

    initial begin
        bit paused_mid;
        paused_mid = 1'b0;

        add_beat(fpq_pkg::ACT_TAKE, 4'd0, '0);
        add_beat(fpq_pkg::ACT_PULL, 4'd0, '0);
        add_beat(fpq_pkg::ACT_RETURN, 4'd15, TIME_MAX);
        add_beat(fpq_pkg::ACT_TAKE, 4'd15, '0);
        add_beat(ACT_SPARE_LO, 4'd0, TIME_MAX);
        add_beat(ACT_SPARE_HI, 4'd15, '0);
        add_beat(fpq_pkg::ACT_INIT, 4'd0, '0);
        add_beat(fpq_pkg::ACT_TAKE, 4'd0, '0);
        add_beat(fpq_pkg::ACT_TAKE, 4'd0, '0);
        add_beat(fpq_pkg::ACT_QUEUE, 4'd0, TIME_MAX);
        add_beat(fpq_pkg::ACT_QUEUE, 4'd1, '0);
        add_beat(fpq_pkg::ACT_START, 4'd0, 40'd100);
        add_beat(fpq_pkg::ACT_PULL, 4'd0, 40'd99);
        add_beat(fpq_pkg::ACT_PULL, 4'd0, 40'd100);
        add_beat(fpq_pkg::ACT_RETURN, 4'd1, '0);
        add_beat(fpq_pkg::ACT_START, 4'd0, 40'd500);
        add_beat(fpq_pkg::ACT_QUEUE, 4'd5, '0);
        add_beat(fpq_pkg::ACT_RETURN, 4'd5, '0);
        add_beat(fpq_pkg::ACT_PULL, 4'd0, TIME_MAX);
        add_beat(fpq_pkg::ACT_INIT, 4'd15, TIME_MAX, 1'b1);

        planned = 0;
        while (planned < RANDOM_ACTIONS) begin
            if (!paused_mid && planned > RANDOM_ACTIONS / 2) begin
                add_beat(fpq_pkg::ACT_PULL, 4'($urandom), rand_time(), 1'b1);
                paused_mid = 1'b1;
            end else if ($urandom_range(0, 3) != 0) begin
                add_session();
            end else begin
                add_beat(fpq_pkg::ACTION_W'($urandom_range(0, 7)), 4'($urandom),
                         rand_time());
            end
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (beats_to_send.size() != 0 || s_valid) @(posedge aclk);
        while (outcomes.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("Ran %0d actions: %0d frames pulled for display, %0d late frames recycled.",
                 actions_done, frames_shown, late_total);
        $display("Sticky fault code at the end of the run: %0d.", fault_now);
        if (errors == 0) begin
            $display("frame_presentation_queue_core: match");
        end else begin
            $display("frame_presentation_queue_core: mismatch");
        end
        $finish;
    end
endmodule
